[design/swlm_pkg.sv]
package swlm_pkg;

  localparam int unsigned BinWidth   = 16;
  localparam int unsigned ColWidth   = 12;
  localparam int unsigned IdxWidth   = 8;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned OutTdataW  = 24;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_DECIMATION = 3'd0,
    REG_BINS_PER_COLUMN  = 3'd1,
    REG_COLUMN_COUNT     = 3'd2,
    REG_MIN_LEVEL        = 3'd3,
    REG_INDEX_GAIN       = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] FrameDecReset = 16'd1;
  localparam logic [6:0]  BinsPerColReset = 7'd1;
  localparam logic [12:0] ColCountReset = 13'd4096;
  localparam logic signed [15:0] MinLevelReset = -16'sd25600;
  localparam logic [15:0] IndexGainReset = 16'd256;
  localparam logic signed [BinWidth-1:0] LevelFloor = {1'b1, {(BinWidth-1){1'b0}}};

endpackage

[design/spectrum_waterfall_line_mapper_top.sv]
// spectrum waterfall line mapper
// input stream: one spectrum bin per item (signed q8.8 dB in tdata), tlast on the
// last bin of each fft frame. output stream: one item per finished display
// column with the column number and palette index in tdata, tlast on the last
// column of a line. only one frame in frame_decimation is mapped; each group of
// bins_per_column bins is max-held and scaled by (max - min_level) * index_gain
// >> 16, clamped to the palette range.
// configuration registers are written through cfg_we_i / cfg_index_i / cfg_data_i
// while the stream is idle; they take effect at once.
// pipeline: input register, column state stage, multiply and clamp stage. a
// result passes the column state and output registers after the edge that accepts
// its last bin. one bin is taken every cycle unless the output is held, and the
// 16x16 multiply is a single stage. all three stages advance together: when the
// output item is held by a low m_axis_tready, s_axis_tready drops and nothing is lost.
// reset clears the frame and column counters, marks the first frame as kept
// and loads the register defaults.
module spectrum_waterfall_line_mapper_top #(
  parameter int unsigned RESOLUTION          = 256,
  parameter int unsigned MAX_COLUMNS         = 4096,
  parameter int unsigned MAX_BINS_PER_COLUMN = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  swlm_pkg::cfg_idx_t                 cfg_index_i,
  input  logic [swlm_pkg::CfgWidth-1:0]      cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [swlm_pkg::InTdataW-1:0]      s_axis_tdata,  // [15:0] bin_value
  input  logic                               s_axis_tlast,  // frame_last
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [swlm_pkg::OutTdataW-1:0]     m_axis_tdata,  // [11:0] column, [19:12] color_index
  output logic                               m_axis_tlast   // line_last
);
  import swlm_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned BW  = $clog2(MAX_BINS_PER_COLUMN + 1);
  localparam int unsigned BIW = (MAX_BINS_PER_COLUMN > 1) ? $clog2(MAX_BINS_PER_COLUMN) : 1;
  localparam logic [15:0] IdxMax = 16'(RESOLUTION - 1);

  // configuration registers
  logic [15:0]        frame_dec_q;
  logic [6:0]         bins_per_col_q;
  logic [12:0]        col_count_q;
  logic signed [15:0] min_level_q;
  logic [15:0]        index_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_dec_q    <= FrameDecReset;
      bins_per_col_q <= BinsPerColReset;
      col_count_q    <= ColCountReset;
      min_level_q    <= MinLevelReset;
      index_gain_q   <= IndexGainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_DECIMATION: frame_dec_q    <= cfg_data_i;
        REG_BINS_PER_COLUMN:  bins_per_col_q <= cfg_data_i[6:0];
        REG_COLUMN_COUNT:     col_count_q    <= cfg_data_i[12:0];
        REG_MIN_LEVEL:        min_level_q    <= cfg_data_i;
        REG_INDEX_GAIN:       index_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective settings
  logic [15:0]   dec;
  logic [BW-1:0] bpc;
  logic [PW-1:0] cols;

  always_comb begin
    dec = (frame_dec_q == 16'd0) ? 16'd1 : frame_dec_q;
    if (bins_per_col_q == 7'd0) begin
      bpc = BW'(1);
    end else if (32'(bins_per_col_q) > MAX_BINS_PER_COLUMN) begin
      bpc = BW'(MAX_BINS_PER_COLUMN);
    end else begin
      bpc = BW'(bins_per_col_q);
    end
    if (col_count_q == 13'd0) begin
      cols = PW'(1);
    end else if (32'(col_count_q) > MAX_COLUMNS) begin
      cols = PW'(MAX_COLUMNS);
    end else begin
      cols = PW'(col_count_q);
    end
  end

  // pipeline control
  logic out_valid_q;
  logic adv;
  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input register
  logic                       in_valid_q;
  logic signed [BinWidth-1:0] in_bin_q;
  logic                       in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_bin_q  <= s_axis_tdata[BinWidth-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  // column state
  logic [15:0]                frame_cnt_q, frame_cnt_d;
  logic                       frame_kept_q, frame_kept_d;
  logic [BIW-1:0]             bin_in_col_q, bin_in_col_d;
  logic [PW-1:0]              col_pos_q, col_pos_d;
  logic signed [BinWidth-1:0] run_max_q, run_max_d;

  logic                       active;
  logic                       emit;
  logic                       line_end;
  logic [BW-1:0]              filled;
  logic signed [BinWidth-1:0] new_max;
  logic [16:0]                next_cnt;

  always_comb begin
    frame_cnt_d  = frame_cnt_q;
    frame_kept_d = frame_kept_q;
    bin_in_col_d = bin_in_col_q;
    col_pos_d    = col_pos_q;
    run_max_d    = run_max_q;
    active   = in_valid_q && frame_kept_q && (col_pos_q < cols);
    filled   = BW'(bin_in_col_q) + BW'(1);
    new_max  = (in_bin_q > run_max_q) ? in_bin_q : run_max_q;
    emit     = active && ((filled >= bpc) || in_last_q);
    line_end = (32'(col_pos_q) + 32'd1 >= 32'(cols)) || in_last_q;
    next_cnt = {1'b0, frame_cnt_q} + 17'd1;
    if (active) begin
      if (emit) begin
        col_pos_d    = col_pos_q + PW'(1);
        bin_in_col_d = '0;
        run_max_d    = LevelFloor;
      end else begin
        bin_in_col_d = BIW'(filled);
        run_max_d    = new_max;
      end
    end
    if (in_valid_q && in_last_q) begin
      frame_cnt_d  = (next_cnt >= {1'b0, dec}) ? 16'd0 : next_cnt[15:0];
      frame_kept_d = (frame_cnt_d == 16'd0);
      bin_in_col_d = '0;
      col_pos_d    = '0;
      run_max_d    = LevelFloor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q  <= '0;
      frame_kept_q <= 1'b1;
      bin_in_col_q <= '0;
      col_pos_q    <= '0;
      run_max_q    <= LevelFloor;
    end else if (adv) begin
      frame_cnt_q  <= frame_cnt_d;
      frame_kept_q <= frame_kept_d;
      bin_in_col_q <= bin_in_col_d;
      col_pos_q    <= col_pos_d;
      run_max_q    <= run_max_d;
    end
  end

  // finished column waiting for scaling
  logic                       mid_valid_q;
  logic signed [BinWidth-1:0] mid_max_q;
  logic [ColWidth-1:0]        mid_col_q;
  logic                       mid_line_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (adv) begin
      mid_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      mid_max_q      <= new_max;
      mid_col_q      <= col_pos_q[ColWidth-1:0];
      mid_line_end_q <= line_end;
    end
  end

  // scale and clamp
  logic signed [16:0] diff;
  logic [31:0]        prod;
  logic [15:0]        idx_full;
  logic [IdxWidth-1:0] idx;

  always_comb begin
    diff     = 17'(mid_max_q) - 17'(min_level_q);
    prod     = 32'(diff[15:0]) * 32'(index_gain_q);
    idx_full = prod[31:16];
    if (diff <= 17'sd0) begin
      idx = '0;
    end else if (idx_full > IdxMax) begin
      idx = IdxMax[IdxWidth-1:0];
    end else begin
      idx = idx_full[IdxWidth-1:0];
    end
  end

  logic [ColWidth-1:0] out_col_q;
  logic [IdxWidth-1:0] out_idx_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && mid_valid_q) begin
      out_col_q  <= mid_col_q;
      out_idx_q  <= idx;
      out_last_q <= mid_line_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdataW - ColWidth - IdxWidth)'(0), out_idx_q, out_col_q};
  assign m_axis_tlast  = out_last_q;

  a_kept_matches_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_kept_q == (frame_cnt_q == 16'd0))
    else $error("frame kept flag out of step with frame counter");

  a_col_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_pos_q) <= MAX_COLUMNS)
    else $error("column position beyond maximum");

  a_mid_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && mid_valid_q |=> out_valid_q)
    else $error("finished column dropped before output");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_valid_q && in_last_q |=> col_pos_q == '0 && bin_in_col_q == '0)
    else $error("column state not cleared at frame end");

endmodule

[tb/sv/line_mapper_checker.sv]
module line_mapper_checker #(
  parameter int unsigned RESOLUTION          = 256,
  parameter int unsigned MAX_COLUMNS         = 4096,
  parameter int unsigned MAX_BINS_PER_COLUMN = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  swlm_pkg::cfg_idx_t                cfg_index_i,
  input  logic [swlm_pkg::CfgWidth-1:0]     cfg_data_i,
  input  logic                              bin_valid_i,
  input  logic                              bin_ready_i,
  input  logic [swlm_pkg::InTdataW-1:0]     bin_data_i,   // [15:0] bin_value
  input  logic                              bin_last_i,   // frame_last
  input  logic                              col_valid_i,
  input  logic                              col_ready_i,
  input  logic [swlm_pkg::OutTdataW-1:0]    col_data_i,   // [11:0] column, [19:12] color_index
  input  logic                              col_last_i,   // line_last
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import swlm_pkg::*;

  typedef struct packed {
    logic [ColWidth-1:0] column;
    logic [IdxWidth-1:0] color_index;
    logic                line_last;
  } column_item_t;

  column_item_t expected_columns[$];

  // register copies
  logic [15:0]        decim;
  logic [6:0]         bins_per_col;
  logic [12:0]        col_limit;
  logic signed [15:0] floor_level;
  logic [15:0]        gain;

  // line state
  int unsigned        frame_ctr;
  bit                 keep_frame;
  int unsigned        bins_held;
  int unsigned        col_pos;
  logic signed [15:0] peak;

  function automatic logic [IdxWidth-1:0] palette_index(input logic signed [15:0] level);
    int     diff;
    longint scaled;
    diff = int'(level) - int'(floor_level);
    if (diff <= 0) return '0;
    scaled = (longint'(diff) * longint'(gain)) >> 16;
    if (scaled > longint'(RESOLUTION) - 1) scaled = longint'(RESOLUTION) - 1;
    return scaled[IdxWidth-1:0];
  endfunction

  task automatic absorb_bin(input logic signed [15:0] level, input logic frame_end);
    int unsigned  dec;
    int unsigned  bpc;
    int unsigned  cols;
    int unsigned  nxt;
    column_item_t item;
    dec  = (decim == 0) ? 1 : decim;
    bpc  = (bins_per_col == 0) ? 1 : bins_per_col;
    cols = (col_limit == 0) ? 1 : col_limit;
    if (bpc > MAX_BINS_PER_COLUMN) bpc = MAX_BINS_PER_COLUMN;
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;

    if (keep_frame && col_pos < cols) begin
      if (level > peak) peak = level;
      // a frame end closes a partly filled column at once
      if (bins_held + 1 >= bpc || frame_end) begin
        item.column      = col_pos[ColWidth-1:0];
        item.color_index = palette_index(peak);
        item.line_last   = (col_pos + 1 >= cols) || frame_end;
        expected_columns.push_back(item);
        col_pos++;
        bins_held = 0;
        peak = LevelFloor;
      end else begin
        bins_held++;
      end
    end

    if (frame_end) begin
      nxt = frame_ctr + 1;
      if (nxt >= dec) nxt = 0;
      frame_ctr  = nxt;
      keep_frame = (nxt == 0);
      bins_held  = 0;
      col_pos    = 0;
      peak       = LevelFloor;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    column_item_t got;
    column_item_t want;
    if (!rst_ni) begin
      decim        = FrameDecReset;
      bins_per_col = BinsPerColReset;
      col_limit    = ColCountReset;
      floor_level  = MinLevelReset;
      gain         = IndexGainReset;
      frame_ctr    = 0;
      keep_frame   = 1'b1;
      bins_held    = 0;
      col_pos      = 0;
      peak         = LevelFloor;
      expected_columns.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (col_valid_i && col_ready_i) begin
        got.column      = col_data_i[ColWidth-1:0];
        got.color_index = col_data_i[ColWidth+IdxWidth-1:ColWidth];
        got.line_last   = col_last_i;
        if (expected_columns.size() == 0) begin
          $error("unexpected column item: column %0d color_index %0d line_last %0b",
                 got.column, got.color_index, got.line_last);
          fail_count_o++;
        end else begin
          want = expected_columns.pop_front();
          if (got.column !== want.column) begin
            $error("column: expected %0d, actual %0d", want.column, got.column);
            fail_count_o++;
          end
          if (got.color_index !== want.color_index) begin
            $error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
            fail_count_o++;
          end
          if (got.line_last !== want.line_last) begin
            $error("line_last: expected %0b, actual %0b", want.line_last, got.line_last);
            fail_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_DECIMATION: decim = cfg_data_i;
          REG_BINS_PER_COLUMN:  bins_per_col = cfg_data_i[6:0];
          REG_COLUMN_COUNT:     col_limit = cfg_data_i[12:0];
          REG_MIN_LEVEL:        floor_level = cfg_data_i;
          REG_INDEX_GAIN:       gain = cfg_data_i;
          default: ;
        endcase
      end

      if (bin_valid_i && bin_ready_i) absorb_bin(bin_data_i, bin_last_i);
      pending_o = expected_columns.size();
    end
  end

endmodule

[tb/sv/spectrum_waterfall_line_mapper_top_test.sv]
module spectrum_waterfall_line_mapper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swlm_pkg::*;

  localparam int unsigned Resolution    = 256;
  localparam int unsigned MaxColumns    = 4096;
  localparam int unsigned MaxBinsPerCol = 64;
  localparam int unsigned PipeSettle    = 4;
  localparam int unsigned ChokeCycles   = 400;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned RandomBins    = 1600;
  localparam int unsigned LongFrameCap  = 160;
  localparam cfg_idx_t    SpareRegFirst = 3'd5;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  cfg_idx_t               cfg_index = REG_FRAME_DECIMATION;
  logic [CfgWidth-1:0]    cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic [InTdataW-1:0]    s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tready = 1'b0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OutTdataW-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  int unsigned check_failures;
  int unsigned columns_pending;
  int unsigned cycle_count = 0;
  int unsigned bins_sent = 0;

  // current register setting, used to shape frames
  logic [6:0]  set_bpc;
  logic [12:0] set_cols;
  logic [15:0] set_min = MinLevelReset;
  bit          steady_sender = 1'b0;
  bit          choke_req = 1'b0;
  bit          choke_served = 1'b0;

  always #10 clk_i = ~clk_i;

  spectrum_waterfall_line_mapper_top #(
    .RESOLUTION         (Resolution),
    .MAX_COLUMNS        (MaxColumns),
    .MAX_BINS_PER_COLUMN(MaxBinsPerCol)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  line_mapper_checker #(
    .RESOLUTION         (Resolution),
    .MAX_COLUMNS        (MaxColumns),
    .MAX_BINS_PER_COLUMN(MaxBinsPerCol)
  ) line_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .bin_valid_i (s_tvalid),
    .bin_ready_i (s_axis_tready),
    .bin_data_i  (s_tdata),
    .bin_last_i  (s_tlast),
    .col_valid_i (m_axis_tvalid),
    .col_ready_i (m_tready),
    .col_data_i  (m_axis_tdata),
    .col_last_i  (m_axis_tlast),
    .fail_count_o(check_failures),
    .pending_o   (columns_pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_level();
    int unsigned r;
    logic [15:0] offset;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom);
    if (r < 8) begin
      // just above min_level, near the bottom of the index scale
      offset = 16'($urandom_range(0, 1024));
      return set_min + offset;
    end
    if (r == 8) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    offset = 16'($urandom_range(1, 64));
    return set_min - offset;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin : rx_loop
      int unsigned gap;
      if (choke_req && !choke_served) begin
        m_tready <= 1'b0;
        repeat (ChokeCycles) @(posedge clk_i);
        choke_served = 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        gap = idle_len();
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  task automatic put_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
  endtask

  task automatic load_setup(input logic [15:0] dec, input logic [6:0] bpc,
                            input logic [12:0] cols, input logic [15:0] lvl,
                            input logic [15:0] gain_v);
    set_bpc  = bpc;
    set_cols = cols;
    set_min  = lvl;
    put_reg(REG_FRAME_DECIMATION, dec);
    put_reg(REG_BINS_PER_COLUMN, {9'd0, bpc});
    put_reg(REG_COLUMN_COUNT, {3'd0, cols});
    put_reg(REG_MIN_LEVEL, lvl);
    put_reg(REG_INDEX_GAIN, gain_v);
    // unmapped index, must leave everything alone
    put_reg(cfg_idx_t'(SpareRegFirst + $urandom_range(0, 2)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_bin(input logic [15:0] level, input logic frame_end);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= level;
    s_tlast  <= frame_end;
    do @(posedge clk_i); while (!s_axis_tready);
    bins_sent++;
    gap = steady_sender ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_bin(pick_level(), k == len - 1);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (columns_pending != 0);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned bpc_eff;
    int unsigned cols_eff;
    int unsigned full;
    int unsigned len;
    int unsigned used;
    int unsigned r;
    bpc_eff  = (set_bpc == 0) ? 1 : ((set_bpc > MaxBinsPerCol) ? MaxBinsPerCol : set_bpc);
    cols_eff = (set_cols == 0) ? 1 : ((set_cols > MaxColumns) ? MaxColumns : set_cols);
    full = bpc_eff * cols_eff;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 3);
      if (full > LongFrameCap) len = $urandom_range(1, LongFrameCap);
      else if (r < 2) len = full;
      else if (r == 2) len = $urandom_range(1, full);
      else len = full + $urandom_range(1, 8);
      send_frame(len);
      used += len;
    end
    drain_block();
  endtask

  task automatic random_setup();
    logic [15:0] dec;
    logic [6:0]  bpc;
    logic [12:0] cols;
    logic [15:0] lvl;
    logic [15:0] gain_v;
    dec    = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 16));
    bpc    = 7'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 127));
    cols   = 13'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(0, 8191));
    lvl    = 16'($urandom);
    gain_v = 16'($urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom);
    steady_sender = ($urandom_range(0, 3) == 0);
    load_setup(dec, bpc, cols, lvl, gain_v);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults: one column per bin, level extremes and scale edges
    send_bin(16'h8000, 1'b0);
    send_bin(16'h7FFF, 1'b0);
    send_bin(MinLevelReset, 1'b1);
    send_bin(MinLevelReset - 16'sd1, 1'b0);
    send_bin(MinLevelReset + 16'sd1, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'hAAAA, 1'b1);
    drain_block();

    // short frame closes a partial column; long frame runs past the last column
    load_setup(16'd1, 7'd3, 13'd2, MinLevelReset, IndexGainReset);
    send_frame(4);
    send_frame(9);
    drain_block();

    // zero and saturating register values
    load_setup(16'd0, 7'd0, 13'd0, 16'h8000, 16'hFFFF);
    run_phase(60);
    load_setup(16'd2, 7'd64, 13'd4096, 16'h7FFF, 16'd0);
    run_phase(200);
    load_setup(16'd1, 7'd1, 13'd64, 16'hCE00, 16'd1024);
    choke_req = 1'b1;
    run_phase(150);
    load_setup(16'hFFFF, 7'h7F, 13'h1FFF, 16'h0000, 16'd1);
    run_phase(150);

    while (bins_sent < RandomBins) begin
      random_setup();
      run_phase($urandom_range(80, 200));
    end

    if (check_failures == 0 && columns_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/swlm_pkg.sv
design/spectrum_waterfall_line_mapper_top.sv
tb/sv/line_mapper_checker.sv
tb/sv/spectrum_waterfall_line_mapper_top_test.sv
